@@ src/msl_pkg.sv @@
// ============================================================================
// msl_pkg
// Shared types and constants for the monotone subsequence length tracker.
// ============================================================================
`default_nettype none

package msl_pkg;

    localparam int MAX_LEN  = 1024;
    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 11;
    localparam int CNT_W    = $clog2(MAX_LEN + 1);
    localparam int GRP      = 32;
    localparam int NUM_GRP  = (MAX_LEN + GRP - 1) / GRP;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [LEN_W-1:0]    len_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    typedef struct packed {
        sample_t sample;
        logic    start_req;
    } item_t;

    typedef struct packed {
        len_t nonincreasing_length;
        len_t increasing_length;
        logic overflow;
    } result_t;

    // one bit per tail array: descending, ascending
    typedef struct packed {
        logic d;
        logic a;
    } pair_t;

    typedef struct packed {
        logic go;
        logic start;
        logic s1;
    } row_ctrl_t;

    typedef struct packed {
        pair_t app;
        pair_t full;
    } row_stat_t;

endpackage

`default_nettype wire

@@ src/monotone_subsequence_lengths.sv @@
// ============================================================================
// monotone_subsequence_lengths
// Running longest non-increasing / strictly increasing subsequence lengths.
// ============================================================================
// An item passes s1 and s2; the result is registered when the output is free.
// No new item is taken before that; the cell row updates in the accept
// cycle, then two register levels reduce the per-cell append flags.
// A finished result may wait in the output register while the next item runs.
// Reset clears all cell valid bits, both lengths and overflow at once.
`default_nettype none

module monotone_subsequence_lengths (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire msl_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output msl_pkg::result_t      result
);

    logic               busy_reg;
    logic               busy_next;
    logic               s1_reg;
    logic               s2_reg;
    logic               s2_next;
    logic               start1_reg;
    logic               start2_reg;
    logic               go;
    logic               done;
    msl_pkg::cnt_t      cnt_d_reg;
    msl_pkg::cnt_t      cnt_a_reg;
    msl_pkg::cnt_t      cnt_d_next;
    msl_pkg::cnt_t      cnt_a_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    msl_pkg::result_t   out_reg;
    msl_pkg::result_t   out_next;
    msl_pkg::row_ctrl_t ctrl;
    msl_pkg::row_stat_t stat;

    assign item_stall = busy_reg;
    assign go         = item_valid & ~busy_reg;
    assign done       = s2_reg & (~out_valid_reg | ~result_stall);

    assign ctrl.go    = go;
    assign ctrl.start = item.start_req;
    assign ctrl.s1    = s1_reg;

    msl_row u_row (
        .clk   (clk),
        .rst_n (rst_n),
        .x     (item.sample),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    always_comb
    begin
        busy_next      = busy_reg;
        s2_next        = s2_reg;
        cnt_d_next     = cnt_d_reg;
        cnt_a_next     = cnt_a_reg;
        ovf_next       = ovf_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & result_stall;
        if (go)
        begin
            busy_next = 1'b1;
        end
        if (s1_reg)
        begin
            s2_next = 1'b1;
        end
        if (done)
        begin
            busy_next      = 1'b0;
            s2_next        = 1'b0;
            cnt_d_next     = msl_pkg::cnt_t'((start2_reg ? '0 : cnt_d_reg)
                                             + msl_pkg::cnt_t'(stat.app.d));
            cnt_a_next     = msl_pkg::cnt_t'((start2_reg ? '0 : cnt_a_reg)
                                             + msl_pkg::cnt_t'(stat.app.a));
            ovf_next       = (ovf_reg & ~start2_reg) | stat.full.d | stat.full.a;
            out_next.nonincreasing_length = msl_pkg::len_t'(cnt_d_next);
            out_next.increasing_length    = msl_pkg::len_t'(cnt_a_next);
            out_next.overflow             = ovf_next;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            s1_reg        <= 1'b0;
            s2_reg        <= 1'b0;
            cnt_d_reg     <= '0;
            cnt_a_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            s1_reg        <= go;
            s2_reg        <= s2_next;
            cnt_d_reg     <= cnt_d_next;
            cnt_a_reg     <= cnt_a_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            start1_reg <= item.start_req;
        end
        if (s1_reg)
        begin
            start2_reg <= start1_reg;
        end
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

@@ src/msl_cell.sv @@
// ============================================================================
// msl_cell
// One tail slot of each array; takes the sample when it is the first match.
// ============================================================================
`default_nettype none

module msl_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire msl_pkg::sample_t x,
    input  wire logic             go,
    input  wire logic             start,
    input  wire msl_pkg::pair_t   prev,
    output msl_pkg::pair_t        next,
    output msl_pkg::pair_t        app
);

    msl_pkg::sample_t tail_d_reg;
    msl_pkg::sample_t tail_a_reg;
    logic             valid_d_reg;
    logic             valid_a_reg;
    logic             valid_d_next;
    logic             valid_a_next;
    msl_pkg::pair_t   app_reg;
    msl_pkg::pair_t   app_next;
    logic             vd_eff;
    logic             va_eff;
    logic             take_d;
    logic             take_a;

    assign vd_eff = valid_d_reg & ~start;
    assign va_eff = valid_a_reg & ~start;

    // empty slots always match, so the first match is a replace or an append
    assign next.d = ~vd_eff | (tail_d_reg < x);
    assign next.a = ~va_eff | (tail_a_reg >= x);

    assign take_d = go & next.d & ~prev.d;
    assign take_a = go & next.a & ~prev.a;

    always_comb
    begin
        valid_d_next = valid_d_reg;
        valid_a_next = valid_a_reg;
        if (go)
        begin
            valid_d_next = vd_eff | take_d;
            valid_a_next = va_eff | take_a;
        end
        app_next.d = take_d & ~vd_eff;
        app_next.a = take_a & ~va_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_d_reg <= 1'b0;
            valid_a_reg <= 1'b0;
            app_reg     <= '0;
        end
        else
        begin
            valid_d_reg <= valid_d_next;
            valid_a_reg <= valid_a_next;
            app_reg     <= app_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_d)
        begin
            tail_d_reg <= x;
        end
        if (take_a)
        begin
            tail_a_reg <= x;
        end
    end

    assign app = app_reg;

endmodule

`default_nettype wire

@@ src/msl_row.sv @@
// ============================================================================
// msl_row
// Chain of tail cells plus a two-level registered reduction of append flags.
// ============================================================================
`default_nettype none

module msl_row (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire msl_pkg::sample_t  x,
    input  wire msl_pkg::row_ctrl_t ctrl,
    output msl_pkg::row_stat_t     stat
);

    msl_pkg::pair_t                  link [msl_pkg::MAX_LEN+1];
    logic [msl_pkg::MAX_LEN-1:0]     app_d;
    logic [msl_pkg::MAX_LEN-1:0]     app_a;
    logic [msl_pkg::NUM_GRP-1:0]     grp_d_next;
    logic [msl_pkg::NUM_GRP-1:0]     grp_a_next;
    logic [msl_pkg::NUM_GRP-1:0]     grp_d_reg;
    logic [msl_pkg::NUM_GRP-1:0]     grp_a_reg;
    msl_pkg::pair_t                  full1_reg;
    msl_pkg::pair_t                  full2_reg;

    assign link[0] = '0;

    for (genvar i = 0; i < msl_pkg::MAX_LEN; i++)
    begin : g_cell
        msl_pkg::pair_t app_w;

        msl_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .x     (x),
            .go    (ctrl.go),
            .start (ctrl.start),
            .prev  (link[i]),
            .next  (link[i+1]),
            .app   (app_w)
        );

        assign app_d[i] = app_w.d;
        assign app_a[i] = app_w.a;
    end

    always_comb
    begin
        grp_d_next = '0;
        grp_a_next = '0;
        for (int g = 0; g < msl_pkg::NUM_GRP; g++)
        begin
            for (int k = 0; k < msl_pkg::GRP; k++)
            begin
                if (g * msl_pkg::GRP + k < msl_pkg::MAX_LEN)
                begin
                    grp_d_next[g] = grp_d_next[g] | app_d[g * msl_pkg::GRP + k];
                    grp_a_next[g] = grp_a_next[g] | app_a[g * msl_pkg::GRP + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.go)
        begin
            // no slot matched anywhere: array full, append dropped
            full1_reg.d <= ~link[msl_pkg::MAX_LEN].d;
            full1_reg.a <= ~link[msl_pkg::MAX_LEN].a;
        end
        if (ctrl.s1)
        begin
            grp_d_reg <= grp_d_next;
            grp_a_reg <= grp_a_next;
            full2_reg <= full1_reg;
        end
    end

    assign stat.app.d = |grp_d_reg;
    assign stat.app.a = |grp_a_reg;
    assign stat.full  = full2_reg;

endmodule

`default_nettype wire

@@ src/msl_chk.sv @@
// ============================================================================
// msl_chk
// Port-level checks for the subsequence length tracker, bound to the top.
// ============================================================================
`default_nettype none

module msl_chk (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             item_valid,
    input wire logic             item_stall,
    input wire msl_pkg::item_t   item,
    input wire logic             result_valid,
    input wire logic             result_stall,
    input wire msl_pkg::result_t result
);

    // stalled result beat is held
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat dropped while stalled");

    // one item in flight: an accepted beat blocks the next cycle
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item accepted while busy");

    // the first sample after reset or start appends to an empty array and lengths only grow, so never zero
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.nonincreasing_length != '0
                      && result.increasing_length != '0)
        else $error("zero length reported");

    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.nonincreasing_length <= msl_pkg::len_t'(msl_pkg::MAX_LEN)
                      && result.increasing_length <= msl_pkg::len_t'(msl_pkg::MAX_LEN))
        else $error("length above capacity");

endmodule

bind monotone_subsequence_lengths msl_chk u_msl_chk (.*);

`default_nettype wire
